/* src/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types and constants of the novelty tuple checker.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int NUM_VARS_DEF   = 8;
  localparam int MAX_DOMAIN_DEF = 8;

  localparam int VALUE_W     = 8;
  localparam int COUNT_W     = 7;
  localparam int LEVEL_W     = 2;
  localparam int DOM_FIELDS  = 8;
  localparam int DOM_FIELD_W = 5;
  localparam int CFG_DATA_W  = DOM_FIELDS * DOM_FIELD_W;
  localparam int CFG_IDX_W   = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_FACTS  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_PAIRS  = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET  = LEVEL_FACTS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL  = 1'b0,
    CFG_DOMAIN = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_VALUE = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    LK_FACT   = 2'd0,
    LK_PAIR   = 2'd1,
    LK_TRIPLE = 2'd2
  } lookup_kind_t;

  typedef struct packed {
    logic         valid;
    logic         clear;
    lookup_kind_t kind;
  } lookup_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_FACT   = 3'd2,
    ST_QSCAN  = 3'd3,
    ST_RSCAN  = 3'd4,
    ST_DRAIN  = 3'd5,
    ST_FINISH = 3'd6
  } seq_state_t;

  // address width of the triple store
  function automatic int trip_aw(input int nv, input int md);
    int span;
    span = nv * md;
    return $clog2(span * span * span);
  endfunction

endpackage

/* src/ntc_ram.sv */
// ----------------------------------------------------------------------------
// ntc_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ntc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/ntc_store.sv */
// ----------------------------------------------------------------------------
// ntc_store
// Seen stores for facts, pairs and triples with test-and-set check stage
// and clear sweep writes. Facts and pairs share one RAM, facts above pairs.
// ----------------------------------------------------------------------------
module ntc_store import ntc_pkg::*; #(
  parameter int NUM_VARS   = NUM_VARS_DEF,
  parameter int MAX_DOMAIN = MAX_DOMAIN_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  lookup_req_t                              req,
  input  logic [trip_aw(NUM_VARS, MAX_DOMAIN)-1:0] req_addr,
  output logic                                     hit_new
);

  localparam int SPAN       = NUM_VARS * MAX_DOMAIN;
  localparam int FACT_DEPTH = SPAN;
  localparam int PAIR_DEPTH = SPAN * SPAN;
  localparam int TRIP_DEPTH = SPAN * SPAN * SPAN;
  localparam int FP_DEPTH   = PAIR_DEPTH + FACT_DEPTH;
  localparam int FACT_AW    = $clog2(FACT_DEPTH);
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int FP_AW      = $clog2(FP_DEPTH);
  localparam int TRIP_AW    = $clog2(TRIP_DEPTH);

  logic               chk_valid_r, chk_valid_nxt;
  lookup_kind_t       chk_kind_r;
  logic [TRIP_AW-1:0] chk_addr_r;

  logic fp_q, trip_q;
  logic chk_seen;
  logic fp_we, trip_we;
  logic fp_re, trip_re;
  logic [FP_AW-1:0]   fp_raddr, fp_chk_addr, fp_waddr;
  logic [TRIP_AW-1:0] trip_waddr;
  logic wdata;

  assign chk_valid_nxt = req.valid && !req.clear;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
    end else begin
      chk_valid_r <= chk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_kind_r <= req.kind;
    chk_addr_r <= req_addr;
  end

  always_comb begin
    case (chk_kind_r)
      LK_FACT:   chk_seen = fp_q;
      LK_PAIR:   chk_seen = fp_q;
      LK_TRIPLE: chk_seen = trip_q;
      default:   chk_seen = 1'b1;
    endcase
  end

  assign hit_new = chk_valid_r && !chk_seen;

  assign fp_re   = chk_valid_nxt && ((req.kind == LK_FACT) || (req.kind == LK_PAIR));
  assign trip_re = chk_valid_nxt && (req.kind == LK_TRIPLE);

  // facts sit above the pairs in the shared store
  assign fp_raddr    = (req.kind == LK_FACT)
                     ? FP_AW'(PAIR_DEPTH) + FP_AW'(req_addr[FACT_AW-1:0])
                     : FP_AW'(req_addr[PAIR_AW-1:0]);
  assign fp_chk_addr = (chk_kind_r == LK_FACT)
                     ? FP_AW'(PAIR_DEPTH) + FP_AW'(chk_addr_r[FACT_AW-1:0])
                     : FP_AW'(chk_addr_r[PAIR_AW-1:0]);

  // clear sweep has priority, new tuples are marked in the cycle after the read
  assign fp_we   = (req.clear && (req_addr < TRIP_AW'(FP_DEPTH)))
                 || (hit_new && ((chk_kind_r == LK_FACT) || (chk_kind_r == LK_PAIR)));
  assign trip_we = req.clear || (hit_new && (chk_kind_r == LK_TRIPLE));

  assign wdata      = !req.clear;
  assign fp_waddr   = req.clear ? req_addr[FP_AW-1:0] : fp_chk_addr;
  assign trip_waddr = req.clear ? req_addr : chk_addr_r;

  ntc_ram #(.WIDTH(1), .DEPTH(FP_DEPTH)) u_fp_ram (
    .clk     (clk),
    .wr_en   (fp_we),
    .wr_addr (fp_waddr),
    .wr_data (wdata),
    .rd_en   (fp_re),
    .rd_addr (fp_raddr),
    .rd_data (fp_q)
  );

  ntc_ram #(.WIDTH(1), .DEPTH(TRIP_DEPTH)) u_trip_ram (
    .clk     (clk),
    .wr_en   (trip_we),
    .wr_addr (trip_waddr),
    .wr_data (wdata),
    .rd_en   (trip_re),
    .rd_addr (req_addr),
    .rd_data (trip_q)
  );

endmodule

/* src/ntc_seq.sv */
// ----------------------------------------------------------------------------
// ntc_seq
// Item sequencer: range check, held values, tuple enumeration, store
// address generation, clear sweep and running count.
// ----------------------------------------------------------------------------
module ntc_seq import ntc_pkg::*; #(
  parameter int NUM_VARS   = NUM_VARS_DEF,
  parameter int MAX_DOMAIN = MAX_DOMAIN_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_cmd,
  input  logic signed [VALUE_W-1:0]                in_var_value,
  input  logic                                     in_last_var,
  input  logic [LEVEL_W-1:0]                       level,
  input  logic [CFG_DATA_W-1:0]                    domain_table,
  input  logic                                     hit_new,
  input  logic                                     slot_free,
  output logic                                     res_load,
  output logic [COUNT_W-1:0]                       res_count,
  output lookup_req_t                              req,
  output logic [trip_aw(NUM_VARS, MAX_DOMAIN)-1:0] req_addr
);

  localparam int SPAN       = NUM_VARS * MAX_DOMAIN;
  localparam int FC_W       = $clog2(SPAN);
  localparam int VAL_W      = $clog2(MAX_DOMAIN);
  localparam int VIDX_W     = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int POS_W      = $clog2(NUM_VARS + 1);
  localparam int TRIP_DEPTH = SPAN * SPAN * SPAN;
  localparam int TRIP_AW    = $clog2(TRIP_DEPTH);

  seq_state_t state_r, state_nxt;

  logic [TRIP_AW-1:0]  clr_cnt_r;
  logic [POS_W-1:0]    pos_r;
  logic [COUNT_W-1:0]  count_r;
  logic [NUM_VARS-1:0] range_r;
  logic [VAL_W-1:0]    held_r [NUM_VARS];
  logic [VIDX_W-1:0]   p_r, q_r, r_r;
  logic [FC_W-1:0]     fp_r, fq_r;
  logic                last_r;

  logic [DOM_FIELD_W-1:0] dom_field [DOM_FIELDS];
  logic [4:0]             pos5;
  logic [DOM_FIELD_W-1:0] dom_raw, dom_sat;
  logic                   acc, is_clear, pos_ok, item_in;
  logic [VIDX_W-1:0]      p_idx, sel_idx;
  logic [VAL_W-1:0]       sel_val;
  logic [FC_W-1:0]        fp_nxt, sel_code;
  logic                   pairs_en, trip_en;
  logic                   q_more, r_more, q_in, r_in;
  logic                   clr_done;

  always_comb begin
    for (int i = 0; i < DOM_FIELDS; i++) begin
      dom_field[i] = domain_table[i*DOM_FIELD_W +: DOM_FIELD_W];
    end
  end

  assign acc      = in_valid && !in_stall;
  assign is_clear = (in_cmd == CMD_CLEAR);
  assign pos_ok   = pos_r < POS_W'(NUM_VARS);
  assign p_idx    = pos_r[VIDX_W-1:0];
  assign pos5     = 5'(pos_r);
  assign dom_raw  = (pos5 < 5'(DOM_FIELDS)) ? dom_field[pos5[2:0]] : '0;
  assign dom_sat  = (dom_raw > DOM_FIELD_W'(MAX_DOMAIN)) ? DOM_FIELD_W'(MAX_DOMAIN)
                                                         : dom_raw;
  assign item_in  = pos_ok && !in_var_value[VALUE_W-1]
                  && ($unsigned(in_var_value) < VALUE_W'(dom_sat));
  assign fp_nxt   = FC_W'(FC_W'(p_idx) * FC_W'(MAX_DOMAIN)
                  + FC_W'(in_var_value[VAL_W-1:0]));

  assign pairs_en = (level != LEVEL_FACTS);
  assign trip_en  = (level != LEVEL_FACTS) && (level != LEVEL_PAIRS);

  // one shared read of the held values: outer index in QSCAN, inner in RSCAN
  assign sel_idx  = (state_r == ST_RSCAN) ? r_r : q_r;
  assign sel_val  = held_r[sel_idx];
  assign sel_code = FC_W'(FC_W'(sel_idx) * FC_W'(MAX_DOMAIN) + FC_W'(sel_val));

  assign q_more   = (POS_W'(q_r) + POS_W'(1)) < POS_W'(p_r);
  assign r_more   = (POS_W'(r_r) + POS_W'(1)) < POS_W'(p_r);
  assign q_in     = range_r[q_r];
  assign r_in     = range_r[r_r];
  assign clr_done = (clr_cnt_r == TRIP_AW'(TRIP_DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if (is_clear)         state_nxt = ST_CLEAR;
          else if (item_in)     state_nxt = ST_FACT;
          else if (in_last_var) state_nxt = ST_FINISH;
        end
      end
      ST_FACT: begin
        if (pairs_en && (p_r != '0)) state_nxt = ST_QSCAN;
        else                         state_nxt = ST_DRAIN;
      end
      ST_QSCAN: begin
        if (trip_en && q_in && q_more) state_nxt = ST_RSCAN;
        else if (!q_more)              state_nxt = ST_DRAIN;
      end
      ST_RSCAN: begin
        if (!r_more) begin
          if (q_more) state_nxt = ST_QSCAN;
          else        state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (last_r) state_nxt = ST_FINISH;
        else        state_nxt = ST_IDLE;
      end
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    res_load  = 1'b0;
    res_count = count_r;
    req       = '{valid: 1'b0, clear: 1'b0, kind: LK_FACT};
    req_addr  = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        req.clear = 1'b1;
      end
      ST_FACT: begin
        req.valid = 1'b1;
        req_addr  = TRIP_AW'(fp_r);
      end
      ST_QSCAN: begin
        req.valid = q_in;
        req.kind  = LK_PAIR;
        req_addr  = TRIP_AW'(TRIP_AW'(sel_code) * TRIP_AW'(SPAN) + TRIP_AW'(fp_r));
      end
      ST_RSCAN: begin
        req.valid = r_in;
        req.kind  = LK_TRIPLE;
        req_addr  = TRIP_AW'(TRIP_AW'(fq_r) * TRIP_AW'(SPAN * SPAN)
                  + TRIP_AW'(sel_code) * TRIP_AW'(SPAN) + TRIP_AW'(fp_r));
      end
      ST_FINISH: begin
        res_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      pos_r     <= '0;
      count_r   <= '0;
      range_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + TRIP_AW'(1);
      end else begin
        clr_cnt_r <= '0;
      end
      if (hit_new && (count_r != COUNT_MAX)) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if ((state_r == ST_IDLE) && acc && !is_clear && pos_ok) begin
        range_r[p_idx] <= item_in;
        pos_r          <= pos_r + POS_W'(1);
      end
      if (res_load) begin
        pos_r   <= '0;
        count_r <= '0;
        range_r <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && acc && !is_clear) begin
      if (item_in) begin
        held_r[p_idx] <= in_var_value[VAL_W-1:0];
      end
      p_r    <= p_idx;
      fp_r   <= fp_nxt;
      last_r <= in_last_var;
      q_r    <= '0;
    end
    if (state_r == ST_QSCAN) begin
      fq_r <= sel_code;
      if (trip_en && q_in && q_more) begin
        r_r <= q_r + VIDX_W'(1);
      end else if (q_more) begin
        q_r <= q_r + VIDX_W'(1);
      end
    end
    if (state_r == ST_RSCAN) begin
      if (r_more) begin
        r_r <= r_r + VIDX_W'(1);
      end else if (q_more) begin
        q_r <= q_r + VIDX_W'(1);
      end
    end
  end

endmodule

/* src/novelty_tuple_checker.sv */
// ----------------------------------------------------------------------------
// novelty_tuple_checker
// Novelty test over facts, pairs and triples of a search state, one
// variable value per transfer, with a count of new tuples per state.
// ----------------------------------------------------------------------------
// an in-range value takes a fact lookup, then pair lookups against held earlier
// in-range values at levels 0, 2 and 3 and triple lookups at levels 0 and 3, one
// store lookup per cycle, then a drain step; an out-of-range value takes none.
// the result is registered once the closing value finishes its lookups and the
// result slot is free. after reset and after each clear command the seen stores
// are swept one entry a cycle: (NUM_VARS*MAX_DOMAIN)**3 entries, 262144 by default.
module novelty_tuple_checker import ntc_pkg::*; #(
  parameter int NUM_VARS   = NUM_VARS_DEF,
  parameter int MAX_DOMAIN = MAX_DOMAIN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic signed [VALUE_W-1:0] in_var_value,
  input  logic                      in_last_var,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COUNT_W-1:0]        out_novelty_count,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int TRIP_AW = trip_aw(NUM_VARS, MAX_DOMAIN);

  logic [LEVEL_W-1:0]    level_r;
  logic [CFG_DATA_W-1:0] domain_r;
  logic                  out_valid_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic               slot_free, res_load, hit_new;
  logic [COUNT_W-1:0] res_count;
  lookup_req_t        req;
  logic [TRIP_AW-1:0] req_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= LEVEL_RESET;
      domain_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_reg_t'(cfg_index) == CFG_LEVEL) begin
        level_r <= cfg_data[LEVEL_W-1:0];
      end
      if (cfg_reg_t'(cfg_index) == CFG_DOMAIN) begin
        domain_r <= cfg_data;
      end
    end
  end

  // result register
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_count_r <= res_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_novelty_count = out_count_r;

  ntc_seq #(.NUM_VARS(NUM_VARS), .MAX_DOMAIN(MAX_DOMAIN)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_var_value (in_var_value),
    .in_last_var  (in_last_var),
    .level        (level_r),
    .domain_table (domain_r),
    .hit_new      (hit_new),
    .slot_free    (slot_free),
    .res_load     (res_load),
    .res_count    (res_count),
    .req          (req),
    .req_addr     (req_addr)
  );

  ntc_store #(.NUM_VARS(NUM_VARS), .MAX_DOMAIN(MAX_DOMAIN)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .req_addr (req_addr),
    .hit_new  (hit_new)
  );

endmodule
